// ----- hw/rtl/fde_pkg.sv -----
// Shared types, constants and register codes for the feedback delay echo.
// Used by fde_seq, fde_mac and feedback_delay_echo; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fde_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int STORE_DEPTH    = 262144;
    localparam int ADDR_BITS      = $clog2(STORE_DEPTH);
    localparam int LEN_BITS       = 19;
    localparam int GAIN_BITS      = 16;
    localparam int MIX_BITS       = 17;
    localparam int Q15_ONE        = 32768;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 19;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DELAY_LENGTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FEEDBACK_GAIN = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WET_MIX       = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNEL_COUNT = 2'd3;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [ADDR_BITS-1:0]          t_addr;

    // one frame entering the pipeline
    typedef struct packed {
        logic  valid;
        logic  bypass;
        logic  two_ch;
        t_addr addr;
    } t_issue;

    // pipeline status back to the sequencer
    typedef struct packed {
        logic en;
        logic s1_valid;
    } t_pipe_status;

    // gains after clamping
    typedef struct packed {
        logic signed [GAIN_BITS-1:0] fb;
        logic [MIX_BITS-1:0]         wet;
        logic [MIX_BITS-1:0]         dry;
    } t_gains;

    // write port into the two channel stores
    typedef struct packed {
        logic    en0;
        logic    en1;
        t_addr   addr;
        t_sample data0;
        t_sample data1;
    } t_wr;

endpackage

`default_nettype wire

// ----- hw/rtl/fde_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fde_ram #(
    parameter  int DEPTH = 1024,
    parameter  int WIDTH = 24,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0]      o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/fde_seq.sv -----
// Sequencer: configuration registers, store clearing sweep, write position.
// Depends on fde_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fde_seq (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [fde_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  wire logic [fde_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  wire logic                                  i_in_valid,
    input  wire fde_pkg::t_pipe_status                 i_status,
    output logic                                       o_in_ready,
    output fde_pkg::t_issue                            o_issue,
    output fde_pkg::t_gains                            o_gains,
    output fde_pkg::t_wr                               o_clr
);

    logic [fde_pkg::LEN_BITS-1:0]         r_delay_length;
    logic signed [fde_pkg::GAIN_BITS-1:0] r_feedback_gain;
    logic [fde_pkg::GAIN_BITS-1:0]        r_wet_mix;
    logic [1:0]                           r_channel_count;
    fde_pkg::t_addr                       r_pos;
    fde_pkg::t_addr                       n_pos;
    logic                                 r_clearing;
    fde_pkg::t_addr                       r_clr_addr;

    logic [fde_pkg::LEN_BITS-1:0] len_eff;
    fde_pkg::t_addr               pos_used;
    logic [fde_pkg::LEN_BITS-1:0] pos_inc;
    logic                         bypass;
    logic                         hazard;
    logic                         accept;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_length  <= '0;
            r_feedback_gain <= '0;
            r_wet_mix       <= '0;
            r_channel_count <= 2'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fde_pkg::CFG_DELAY_LENGTH:  r_delay_length  <= i_cfg_data;
                fde_pkg::CFG_FEEDBACK_GAIN: r_feedback_gain <= i_cfg_data[fde_pkg::GAIN_BITS-1:0];
                fde_pkg::CFG_WET_MIX:       r_wet_mix       <= i_cfg_data[fde_pkg::GAIN_BITS-1:0];
                fde_pkg::CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // clamp delay and mix
    always_comb begin
        if (r_delay_length > fde_pkg::LEN_BITS'(fde_pkg::STORE_DEPTH)) begin
            len_eff = fde_pkg::LEN_BITS'(fde_pkg::STORE_DEPTH);
        end else begin
            len_eff = r_delay_length;
        end
        if ({1'b0, r_wet_mix} > fde_pkg::MIX_BITS'(fde_pkg::Q15_ONE)) begin
            o_gains.wet = fde_pkg::MIX_BITS'(fde_pkg::Q15_ONE);
        end else begin
            o_gains.wet = {1'b0, r_wet_mix};
        end
        o_gains.dry = fde_pkg::MIX_BITS'(fde_pkg::Q15_ONE) - o_gains.wet;
        o_gains.fb  = r_feedback_gain;
    end

    // position: drop a stale position, advance and wrap
    always_comb begin
        bypass = (len_eff == '0);
        if ({1'b0, r_pos} >= len_eff) begin
            pos_used = '0;
        end else begin
            pos_used = r_pos;
        end
        pos_inc = {1'b0, pos_used} + fde_pkg::LEN_BITS'(1);
        if (pos_inc >= len_eff) begin
            n_pos = '0;
        end else begin
            n_pos = pos_inc[fde_pkg::ADDR_BITS-1:0];
        end
    end

    // with a one-frame delay the previous frame's write must land first
    assign hazard     = (len_eff == fde_pkg::LEN_BITS'(1)) && i_status.s1_valid;
    assign o_in_ready = i_status.en && !r_clearing && !hazard;
    assign accept     = i_in_valid && o_in_ready;

    assign o_issue.valid  = accept;
    assign o_issue.bypass = bypass;
    assign o_issue.two_ch = r_channel_count[1];
    assign o_issue.addr   = pos_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (accept && !bypass) begin
            r_pos <= n_pos;
        end
    end

    // zero sweep over the store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + fde_pkg::ADDR_BITS'(1);
            if (r_clr_addr == fde_pkg::ADDR_BITS'(fde_pkg::STORE_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign o_clr.en0   = r_clearing;
    assign o_clr.en1   = r_clearing;
    assign o_clr.addr  = r_clr_addr;
    assign o_clr.data0 = '0;
    assign o_clr.data1 = '0;

    a_len_one_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (len_eff == fde_pkg::LEN_BITS'(1)) |-> !i_status.s1_valid)
        else $error("frame accepted over an in-flight frame at the same slot");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !bypass |=> ({1'b0, r_pos} < $past(len_eff)))
        else $error("write position left the delay range");

    a_idle_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !i_status.s1_valid && !accept)
        else $error("frame in flight during store clearing");

endmodule

`default_nettype wire

// ----- hw/rtl/fde_mac.sv -----
// Datapath: forwarding, gain products, round/saturate, write-back, output register.
// Depends on fde_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fde_mac (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire fde_pkg::t_issue         i_issue,
    input  wire fde_pkg::t_sample        i_left,
    input  wire fde_pkg::t_sample        i_right,
    input  wire fde_pkg::t_gains         i_gains,
    input  wire fde_pkg::t_sample        i_rd_left,
    input  wire fde_pkg::t_sample        i_rd_right,
    input  wire logic                    i_out_ready,
    output fde_pkg::t_pipe_status        o_status,
    output fde_pkg::t_wr                 o_wr,
    output logic                         o_out_valid,
    output fde_pkg::t_sample             o_left_out,
    output fde_pkg::t_sample             o_right_out
);

    localparam int SUM_BITS = 42;
    typedef logic signed [SUM_BITS-1:0] t_sum;

    function automatic fde_pkg::t_sample sat_round(input t_sum s);
        t_sum r;
        r = (s + t_sum'(fde_pkg::Q15_ONE / 2)) >>> 15;
        if (r > t_sum'(2 ** (fde_pkg::SAMPLE_BITS - 1) - 1)) begin
            r = t_sum'(2 ** (fde_pkg::SAMPLE_BITS - 1) - 1);
        end else if (r < -t_sum'(2 ** (fde_pkg::SAMPLE_BITS - 1))) begin
            r = -t_sum'(2 ** (fde_pkg::SAMPLE_BITS - 1));
        end
        return r[fde_pkg::SAMPLE_BITS-1:0];
    endfunction

    logic en;

    // stage 1: memory data arrives
    logic             r_s1_valid;
    logic             r_s1_bypass;
    logic             r_s1_two;
    fde_pkg::t_addr   r_s1_addr;
    fde_pkg::t_sample r_s1_x0;
    fde_pkg::t_sample r_s1_x1;

    // last write, for a read that met a write at the same edge
    logic             r_fw_v0;
    logic             r_fw_v1;
    fde_pkg::t_addr   r_fw_addr;
    fde_pkg::t_sample r_fw_d0;
    fde_pkg::t_sample r_fw_d1;

    fde_pkg::t_sample d0;
    fde_pkg::t_sample d1;
    t_sum             n_fb0, n_fb1, n_dry0, n_dry1, n_wet0, n_wet1;

    // stage 2: products held
    logic             r_s2_valid;
    logic             r_s2_bypass;
    logic             r_s2_two;
    fde_pkg::t_addr   r_s2_addr;
    fde_pkg::t_sample r_s2_x0;
    fde_pkg::t_sample r_s2_x1;
    t_sum             r_fb0, r_fb1, r_dry0, r_dry1, r_wet0, r_wet1;

    fde_pkg::t_sample back0, back1, mix0, mix1;

    // output register
    logic             r_out_valid;
    fde_pkg::t_sample r_left_out;
    fde_pkg::t_sample r_right_out;

    assign en = !r_out_valid || i_out_ready;
    assign o_status.en       = en;
    assign o_status.s1_valid = r_s1_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= i_issue.valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_bypass <= i_issue.bypass;
            r_s1_two    <= i_issue.two_ch;
            r_s1_addr   <= i_issue.addr;
            r_s1_x0     <= i_left;
            r_s1_x1     <= i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_v0 <= 1'b0;
            r_fw_v1 <= 1'b0;
        end else if (o_wr.en0) begin
            r_fw_v0 <= 1'b1;
            r_fw_v1 <= o_wr.en1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_wr.en0) begin
            r_fw_addr <= o_wr.addr;
            r_fw_d0   <= o_wr.data0;
            r_fw_d1   <= o_wr.data1;
        end
    end

    always_comb begin
        d0 = (r_fw_v0 && (r_fw_addr == r_s1_addr)) ? r_fw_d0 : i_rd_left;
        d1 = (r_fw_v1 && (r_fw_addr == r_s1_addr)) ? r_fw_d1 : i_rd_right;
        n_fb0  = d0 * i_gains.fb;
        n_fb1  = d1 * i_gains.fb;
        n_dry0 = r_s1_x0 * $signed({1'b0, i_gains.dry});
        n_dry1 = r_s1_x1 * $signed({1'b0, i_gains.dry});
        n_wet0 = d0 * $signed({1'b0, i_gains.wet});
        n_wet1 = d1 * $signed({1'b0, i_gains.wet});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_bypass <= r_s1_bypass;
            r_s2_two    <= r_s1_two;
            r_s2_addr   <= r_s1_addr;
            r_s2_x0     <= r_s1_x0;
            r_s2_x1     <= r_s1_x1;
            r_fb0       <= n_fb0;
            r_fb1       <= n_fb1;
            r_dry0      <= n_dry0;
            r_dry1      <= n_dry1;
            r_wet0      <= n_wet0;
            r_wet1      <= n_wet1;
        end
    end

    always_comb begin
        back0 = sat_round((t_sum'(r_s2_x0) <<< 15) + r_fb0);
        back1 = sat_round((t_sum'(r_s2_x1) <<< 15) + r_fb1);
        mix0  = sat_round(r_dry0 + r_wet0);
        mix1  = sat_round(r_dry1 + r_wet1);
    end

    assign o_wr.en0  = en && r_s2_valid && !r_s2_bypass;
    assign o_wr.en1  = en && r_s2_valid && !r_s2_bypass && r_s2_two;
    assign o_wr.addr = r_s2_addr;
    assign o_wr.data0 = back0;
    assign o_wr.data1 = back1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_left_out  <= r_s2_bypass ? r_s2_x0 : mix0;
            if (!r_s2_two) begin
                r_right_out <= '0;
            end else begin
                r_right_out <= r_s2_bypass ? r_s2_x1 : mix1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

    a_write_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.en0 |=> r_out_valid)
        else $error("store written without a result reaching the output");

    a_right_needs_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.en1 |-> o_wr.en0)
        else $error("right channel written without left channel");

    a_no_adjacent_same_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_s1_valid && r_s2_valid && !r_s1_bypass && !r_s2_bypass
          && (r_s1_addr == r_s2_addr)))
        else $error("adjacent frames on the same slot; forwarding would miss");

endmodule

`default_nettype wire

// ----- hw/rtl/feedback_delay_echo.sv -----
// Pipeline: an accepted input word passes stage 1, stage 2 and the output register.
// Throughput: one frame per cycle unless the output stalls; with a delay length of 1,
// a frame waits while the previous one is in stage 1, whose write-back slot it reads.
// Reset: synchronous, active low; registers take their reset values, then a zero
// sweep clears the 262144-slot delay store, with o_ready low (config writes taken).
// Depends on fde_pkg, fde_seq, fde_mac and fde_ram.
`timescale 1ns / 1ps
`default_nettype none

module feedback_delay_echo (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration write port
    input  wire logic                                  i_cfg_we,
    input  wire logic [fde_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  wire logic [fde_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    // input frames
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire fde_pkg::t_sample                      i_left_sample,
    input  wire fde_pkg::t_sample                      i_right_sample,
    // output frames
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output fde_pkg::t_sample                           o_left_out,
    output fde_pkg::t_sample                           o_right_out
);

    fde_pkg::t_issue       issue;
    fde_pkg::t_gains       gains;
    fde_pkg::t_pipe_status status;
    fde_pkg::t_wr          clr_wr;
    fde_pkg::t_wr          mac_wr;
    fde_pkg::t_wr          wr;
    fde_pkg::t_sample      rd_left;
    fde_pkg::t_sample      rd_right;

    // Sequencer: holds the registers, picks the slot for each word and
    // stalls input during the clearing sweep, a same-slot conflict or an output stall.
    fde_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_valid),
        .i_status    (status),
        .o_in_ready  (o_ready),
        .o_issue     (issue),
        .o_gains     (gains),
        .o_clr       (clr_wr)
    );

    // The sweep owns the write port while it runs; no words are in flight then.
    assign wr = clr_wr.en0 ? clr_wr : mac_wr;

    // One store per channel; slot address is the write position.
    // Reads advance with the pipeline so read data holds during a stall.
    fde_ram #(
        .DEPTH (fde_pkg::STORE_DEPTH),
        .WIDTH (fde_pkg::SAMPLE_BITS)
    ) u_ram_left (
        .i_clk   (i_clk),
        .i_we    (wr.en0),
        .i_waddr (wr.addr),
        .i_wdata (wr.data0),
        .i_re    (status.en),
        .i_raddr (issue.addr),
        .o_rdata (rd_left)
    );

    fde_ram #(
        .DEPTH (fde_pkg::STORE_DEPTH),
        .WIDTH (fde_pkg::SAMPLE_BITS)
    ) u_ram_right (
        .i_clk   (i_clk),
        .i_we    (wr.en1),
        .i_waddr (wr.addr),
        .i_wdata (wr.data1),
        .i_re    (status.en),
        .i_raddr (issue.addr),
        .o_rdata (rd_right)
    );

    // Datapath: stage 1 forwards and multiplies, stage 2 rounds, saturates
    // and writes back, then the output register holds the word for the sink.
    fde_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_left      (i_left_sample),
        .i_right     (i_right_sample),
        .i_gains     (gains),
        .i_rd_left   (rd_left),
        .i_rd_right  (rd_right),
        .i_out_ready (i_ready),
        .o_status    (status),
        .o_wr        (mac_wr),
        .o_out_valid (o_valid),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out)
    );

endmodule

`default_nettype wire

// ----- sim/feedback_delay_echo_test.sv -----
// Self-checking testbench for feedback_delay_echo: directed and random frames,
// predicted by an in-bench echo model and checked word by word.
// Depends on fde_pkg and the feedback_delay_echo RTL.
`timescale 1ns / 1ps

module feedback_delay_echo_test;

    localparam int CYCLE_LIMIT   = 1000000; // covers the store-clear sweep several times over
    localparam int DRAIN_CYCLES  = 4;       // covers stage 1, stage 2 and the output register
    localparam int RANDOM_FRAMES = 800;
    localparam int CALM_FRAMES   = 150;     // tail of the run with no idling
    localparam longint SAMPLE_MAX = (longint'(1) <<< (fde_pkg::SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -(longint'(1) <<< (fde_pkg::SAMPLE_BITS - 1));

    typedef struct {
        fde_pkg::t_sample left;
        fde_pkg::t_sample right;
    } t_echo_frame;

    // DUT connections; every input starts at a known value
    logic                               i_clk          = 1'b0;
    logic                               i_rst_n        = 1'b0;
    logic                               i_cfg_we       = 1'b0;
    logic [fde_pkg::CFG_INDEX_BITS-1:0] i_cfg_index    = '0;
    logic [fde_pkg::CFG_DATA_BITS-1:0]  i_cfg_data     = '0;
    logic                               i_valid        = 1'b0;
    logic                               o_ready;
    fde_pkg::t_sample                   i_left_sample  = '0;
    fde_pkg::t_sample                   i_right_sample = '0;
    logic                               o_valid;
    logic                               i_ready        = 1'b0;
    fde_pkg::t_sample                   o_left_out;
    fde_pkg::t_sample                   o_right_out;

    // echo model state: mirror of the store, the ring position and the registers
    bit signed [fde_pkg::SAMPLE_BITS-1:0] echo_mem [2*fde_pkg::STORE_DEPTH];
    int unsigned                          ring_pos = 0;
    logic [fde_pkg::LEN_BITS-1:0]         delay_reg = '0;
    logic signed [15:0]                   feedback_reg = '0;
    logic [15:0]                          wet_reg = '0;
    logic [1:0]                           chans_reg = 2'd2;

    t_echo_frame pending_echoes[$];
    t_echo_frame arrived;
    int          error_count = 0;
    int          stall_left = 0;
    int          cycle_count = 0;
    bit          idle_on = 1'b1;

    feedback_delay_echo u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_left_out     (o_left_out),
        .o_right_out    (o_right_out)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Hard stop in case a handshake never completes.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Round a Q1.15-scaled sum to the sample grid (floor after adding half,
    // so ties go toward +infinity), then clamp to the signed sample range.
    function automatic fde_pkg::t_sample q15_round_clamp(input longint acc);
        longint v;
        v = (acc + 16384) >>> 15;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        if (v < SAMPLE_MIN) v = SAMPLE_MIN;
        return fde_pkg::t_sample'(v);
    endfunction

    // Advance the echo model by one frame and return the word it must produce.
    function automatic t_echo_frame predict_echo(input fde_pkg::t_sample left,
                                                 input fde_pkg::t_sample right);
        t_echo_frame res;
        int unsigned len, nch, slot;
        longint      fb, wet, x, d;
        len = (delay_reg > fde_pkg::STORE_DEPTH) ? fde_pkg::STORE_DEPTH : delay_reg;
        nch = (chans_reg == 2'd0) ? 1 : ((chans_reg > 2'd2) ? 2 : chans_reg);
        fb  = feedback_reg;
        wet = (wet_reg > fde_pkg::Q15_ONE) ? fde_pkg::Q15_ONE : wet_reg;
        res.left  = left;
        res.right = (nch == 2) ? right : '0;
        // bypass: pass through, leave store and position alone
        if (len == 0)
            return res;
        // a shortened delay can leave the position out of range
        if (ring_pos >= len)
            ring_pos = 0;
        for (int ch = 0; ch < nch; ch++) begin
            slot = ring_pos * 2 + ch;
            x = (ch == 0) ? longint'(left) : longint'(right);
            d = echo_mem[slot];
            echo_mem[slot] = q15_round_clamp(x * fde_pkg::Q15_ONE + d * fb);
            if (ch == 0)
                res.left = q15_round_clamp(x * (fde_pkg::Q15_ONE - wet) + d * wet);
            else
                res.right = q15_round_clamp(x * (fde_pkg::Q15_ONE - wet) + d * wet);
        end
        ring_pos++;
        if (ring_pos >= len)
            ring_pos = 0;
        return res;
    endfunction

    // Mostly full-range samples, with a fair share of rails and small values.
    function automatic fde_pkg::t_sample pick_sample();
        case ($urandom_range(0, 7))
            0: return fde_pkg::t_sample'(SAMPLE_MAX);
            1: return fde_pkg::t_sample'(SAMPLE_MIN);
            2: return fde_pkg::t_sample'($signed($urandom_range(0, 512)) - 256);
            default: return fde_pkg::t_sample'($urandom);
        endcase
    endfunction

    // Drain the pipeline, then write all four registers back to back.
    // Upper data bits beyond a register's width carry junk on purpose.
    task automatic configure(input logic [fde_pkg::LEN_BITS-1:0] dly, input logic [15:0] fb,
                             input logic [15:0] wet, input logic [1:0] chans);
        i_valid <= 1'b0;
        while (pending_echoes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= fde_pkg::CFG_DELAY_LENGTH;
        i_cfg_data  <= dly;
        @(posedge i_clk);
        i_cfg_index <= fde_pkg::CFG_FEEDBACK_GAIN;
        i_cfg_data  <= {3'($urandom), fb};
        @(posedge i_clk);
        i_cfg_index <= fde_pkg::CFG_WET_MIX;
        i_cfg_data  <= {3'($urandom), wet};
        @(posedge i_clk);
        i_cfg_index <= fde_pkg::CFG_CHANNEL_COUNT;
        i_cfg_data  <= {17'($urandom), chans};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        delay_reg    = dly;
        feedback_reg = fb;
        wet_reg      = wet;
        chans_reg    = chans;
    endtask

    // Offer one frame, hold it until taken, then log the word it must produce.
    task automatic send_frame(input fde_pkg::t_sample left, input fde_pkg::t_sample right);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_left_sample  <= left;
        i_right_sample <= right;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        pending_echoes.push_back(predict_echo(left, right));
    endtask

    // Check each output word against the oldest prediction; drive the
    // receiver stalls in random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_echoes.size() == 0) begin
                    $error("output word with no frame pending");
                    error_count++;
                end else begin
                    arrived = pending_echoes.pop_front();
                    if (o_left_out !== arrived.left) begin
                        $error("left_out: expected %0d, actual %0d", arrived.left, o_left_out);
                        error_count++;
                    end
                    if (o_right_out !== arrived.right) begin
                        $error("right_out: expected %0d, actual %0d",
                               arrived.right, o_right_out);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Bypass: words pass straight through; one channel zeroes right_out.
    task automatic test_bypass();
        configure(19'd0, 16'h7FFF, 16'd32768, 2'd2);
        send_frame(fde_pkg::t_sample'(SAMPLE_MAX), fde_pkg::t_sample'(SAMPLE_MIN));
        send_frame(fde_pkg::t_sample'(SAMPLE_MIN), fde_pkg::t_sample'(SAMPLE_MAX));
        send_frame(fde_pkg::t_sample'(0), fde_pkg::t_sample'(-1));
        configure(19'd0, 16'h0000, 16'd0, 2'd1);
        send_frame(fde_pkg::t_sample'(-1), fde_pkg::t_sample'(12345));
    endtask

    // Rails with extreme gains; excess mix and count 3 clamp.
    task automatic test_saturation();
        configure(19'd3, 16'h8000, 16'd32768, 2'd2);
        repeat (4) send_frame(fde_pkg::t_sample'(SAMPLE_MAX), fde_pkg::t_sample'(SAMPLE_MIN));
        configure(19'd2, 16'h7FFF, 16'hFFFF, 2'd3);
        send_frame(fde_pkg::t_sample'(SAMPLE_MIN), fde_pkg::t_sample'(SAMPLE_MAX));
        send_frame(fde_pkg::t_sample'(SAMPLE_MAX), fde_pkg::t_sample'(SAMPLE_MAX));
    endtask

    // Shorten the delay below the current ring position.
    task automatic test_stale_position();
        configure(19'd10, 16'h4000, 16'h4000, 2'd2);
        repeat (5) send_frame(pick_sample(), pick_sample());
        configure(19'd4, 16'h4000, 16'h4000, 2'd2);
        repeat (2) send_frame(pick_sample(), pick_sample());
    endtask

    // Count 0 runs one channel; the right slots must survive untouched.
    task automatic test_unused_channel();
        configure(19'd3, 16'h2000, 16'd20000, 2'd0);
        repeat (3) send_frame(pick_sample(), pick_sample());
        configure(19'd3, 16'h2000, 16'd20000, 2'd2);
        repeat (2) send_frame(pick_sample(), pick_sample());
    endtask

    // Delay above the store depth, then the tightest loop of one frame.
    task automatic test_delay_extremes();
        configure(19'h7FFFF, 16'h7FFF, 16'd32768, 2'd2);
        repeat (2) send_frame(pick_sample(), pick_sample());
        idle_on = 1'b0;
        configure(19'd1, 16'hC000, 16'd8192, 2'd2);
        repeat (3) send_frame(pick_sample(), pick_sample());
        idle_on = 1'b1;
    endtask

    // Random settings per phase, mostly short delays so echoes come back.
    task automatic test_random_phases();
        int                           sent, batch, pick;
        logic [fde_pkg::LEN_BITS-1:0] dly;
        logic [15:0]                  fb, wet;
        sent = 0;
        while (sent < RANDOM_FRAMES) begin
            if (sent >= RANDOM_FRAMES - CALM_FRAMES)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 4) != 0);
            pick = $urandom_range(0, 19);
            if (pick < 2)
                dly = '0;
            else if (pick < 15)
                dly = fde_pkg::LEN_BITS'($urandom_range(1, 40));
            else if (pick < 17)
                dly = 19'd1;
            else if (pick == 17)
                dly = fde_pkg::LEN_BITS'(fde_pkg::STORE_DEPTH);
            else if (pick == 18)
                dly = 19'h7FFFF;
            else
                dly = fde_pkg::LEN_BITS'($urandom);
            case ($urandom_range(0, 5))
                0: fb = 16'h8000;
                1: fb = 16'h7FFF;
                default: fb = 16'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0: wet = 16'd0;
                1: wet = 16'd32768;
                2: wet = 16'($urandom);
                default: wet = 16'($urandom_range(0, 32768));
            endcase
            configure(dly, fb, wet, 2'($urandom_range(0, 3)));
            batch = $urandom_range(20, 60);
            repeat (batch) send_frame(pick_sample(), pick_sample());
            sent += batch;
        end
    endtask

    initial begin
        // hold reset, then release; the store-clear sweep keeps o_ready low
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_bypass();
        test_saturation();
        test_stale_position();
        test_unused_channel();
        test_delay_extremes();
        test_random_phases();

        // drop valid, wait out the last words and the pipeline tail
        i_valid <= 1'b0;
        while (pending_echoes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES * 4) @(posedge i_clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
